>>> rtl/core/krs_pkg.sv
// ----------------------------------------------------------------------------
// krs_pkg
// Types and codes used by the keyed record stack and its testbench.
// ----------------------------------------------------------------------------
package krs_pkg;

    localparam int KIND_W  = 3;
    localparam int KEY_W   = 32;
    localparam int QTY_W   = 32;
    localparam int ST_W    = 2;
    localparam int ERR_W   = 2;
    localparam int REC_W   = KEY_W + QTY_W + ST_W;
    localparam int TDATA_W = 72;

    // command kinds
    localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd4;

    // result codes
    localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY     = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NOT_FOUND = 2'd2;
    localparam logic [ERR_W-1:0] ERR_FULL      = 2'd3;

    // one stored record, key in the lowest bits
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [QTY_W-1:0] quantity;
        logic [KEY_W-1:0] record_key;
    } t_rec;

endpackage

>>> rtl/core/krs_ram.sv
// ----------------------------------------------------------------------------
// krs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module krs_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/keyed_record_stack.sv
// ----------------------------------------------------------------------------
// keyed_record_stack
// Bounded LIFO stack of records (key, quantity, status) with search and
// status update by key, scanned from the top with one shared comparator.
// ----------------------------------------------------------------------------
// usage:
//   slave stream carries one command per transaction: tuser is the kind,
//   tdata holds record_key, quantity and status. master stream returns one
//   result per command: error_code, out_key, out_quantity, out_status.
//   push, unused kinds and any pop, peek, search or update on an empty
//   stack answer in the cycle after the command is taken.
//   pop and peek on a non-empty stack read the top entry through the
//   registered ram port and answer through the output register. search and update walk
//   the stack from the top, one ram read per cycle into the comparator, and
//   answer once a key matches or the bottom entry has been compared.
//   only one command is in work at a time; s_axis_tready is low while a
//   scan runs. a result waiting in the output register does not block the
//   next command if the receiver takes it in that same cycle, so pushes,
//   unused kinds and commands on an empty stack can follow back to back.
//   reset empties the stack (fill count to zero) and drops any pending
//   result; the record ram is not cleared. while the receiver stalls the
//   result holds and no further command is taken.
// ----------------------------------------------------------------------------
module keyed_record_stack #(
    parameter int DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // record_key [31:0], quantity [63:32], status [65:64], zero pad [71:66]
    input  logic [krs_pkg::TDATA_W-1:0] s_axis_tdata,
    // kind [2:0]
    input  logic [krs_pkg::KIND_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // error_code [1:0], out_key [33:2], out_quantity [65:34],
    // out_status [67:66], zero pad [71:68]
    output logic [krs_pkg::TDATA_W-1:0] m_axis_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [0:0] {S_IDLE, S_SCAN} t_state;

    t_state                       r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic [AW-1:0]                r_ptr, n_ptr;
    logic [CW-1:0]                r_left, n_left;
    logic                         r_pend, n_pend;
    logic [AW-1:0]                r_cmp, n_cmp;
    logic [krs_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic [krs_pkg::KEY_W-1:0]    r_key, n_key;
    logic [krs_pkg::ST_W-1:0]     r_st, n_st;
    logic                         r_out_valid, n_out_valid;
    logic [krs_pkg::ERR_W-1:0]    r_out_err, n_out_err;
    krs_pkg::t_rec                r_out_rec, n_out_rec;

    logic                         w_s_acc;
    krs_pkg::t_rec                w_in_rec;
    krs_pkg::t_rec                w_rd_rec;
    logic [krs_pkg::REC_W-1:0]    w_rdata;
    logic [CW-1:0]                w_top;
    logic                         w_full;
    logic                         w_empty;
    logic                         w_any;
    logic                         w_hit;
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    krs_pkg::t_rec                w_wrec;

    assign w_in_rec.record_key = s_axis_tdata[31:0];
    assign w_in_rec.quantity   = s_axis_tdata[63:32];
    assign w_in_rec.status     = s_axis_tdata[65:64];

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;

    assign w_top   = r_count - CW'(1);
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_rd_rec = krs_pkg::t_rec'(w_rdata);

    // pop and peek take whatever sits on top, search and update need a key match
    assign w_any = (r_kind == krs_pkg::KIND_POP) || (r_kind == krs_pkg::KIND_PEEK);
    assign w_hit = (r_state == S_SCAN) && r_pend &&
                   (w_any || (w_rd_rec.record_key == r_key));

    krs_ram #(
        .WIDTH (krs_pkg::REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wrec),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_pend      = r_pend;
        n_cmp       = r_cmp;
        n_kind      = r_kind;
        n_key       = r_key;
        n_st        = r_st;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_err   = r_out_err;
        n_out_rec   = r_out_rec;
        w_we        = 1'b0;
        w_waddr     = r_cmp;
        w_wrec      = w_rd_rec;
        w_wrec.status = r_st;

        case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    n_kind = s_axis_tuser;
                    n_key  = w_in_rec.record_key;
                    n_st   = w_in_rec.status;
                    n_pend = 1'b0;
                    case (s_axis_tuser)
                        krs_pkg::KIND_PUSH: begin
                            n_out_valid = 1'b1;
                            if (w_full) begin
                                n_out_err = krs_pkg::ERR_FULL;
                                n_out_rec = '0;
                            end else begin
                                w_we      = 1'b1;
                                w_waddr   = r_count[AW-1:0];
                                w_wrec    = w_in_rec;
                                n_count   = r_count + CW'(1);
                                n_out_err = krs_pkg::ERR_OK;
                                n_out_rec = w_in_rec;
                            end
                        end
                        krs_pkg::KIND_POP, krs_pkg::KIND_PEEK: begin
                            if (w_empty) begin
                                n_out_valid = 1'b1;
                                n_out_err   = krs_pkg::ERR_EMPTY;
                                n_out_rec   = '0;
                            end else begin
                                n_ptr   = w_top[AW-1:0];
                                n_left  = CW'(1);
                                n_state = S_SCAN;
                            end
                        end
                        krs_pkg::KIND_SEARCH, krs_pkg::KIND_UPDATE: begin
                            if (w_empty) begin
                                n_out_valid = 1'b1;
                                n_out_err   = krs_pkg::ERR_NOT_FOUND;
                                n_out_rec   = '0;
                            end else begin
                                n_ptr   = w_top[AW-1:0];
                                n_left  = r_count;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_err   = krs_pkg::ERR_OK;
                            n_out_rec   = '0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_out_valid = 1'b1;
                    n_out_err   = krs_pkg::ERR_OK;
                    n_out_rec   = w_rd_rec;
                    if (r_kind == krs_pkg::KIND_UPDATE) begin
                        w_we             = 1'b1;
                        n_out_rec.status = r_st;
                    end
                    if (r_kind == krs_pkg::KIND_POP) begin
                        n_count = w_top;
                    end
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end else if (r_pend && (r_left == '0)) begin
                    // bottom entry compared without a match
                    n_out_valid = 1'b1;
                    n_out_err   = krs_pkg::ERR_NOT_FOUND;
                    n_out_rec   = '0;
                    n_pend      = 1'b0;
                    n_state     = S_IDLE;
                end else if (r_left != '0) begin
                    // issue next read while the previous one is compared
                    n_pend = 1'b1;
                    n_cmp  = r_ptr;
                    n_ptr  = r_ptr - AW'(1);
                    n_left = r_left - CW'(1);
                end else begin
                    n_pend = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_ptr     <= n_ptr;
        r_left    <= n_left;
        r_cmp     <= n_cmp;
        r_kind    <= n_kind;
        r_key     <= n_key;
        r_st      <= n_st;
        r_out_err <= n_out_err;
        r_out_rec <= n_out_rec;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_rec.status, r_out_rec.quantity,
                            r_out_rec.record_key, r_out_err};

    // fill count never passes the stack depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    // a scan always finds the output register free when it finishes
    a_scan_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_out_valid)
        else $error("output register busy during scan");

    // a compare is only pending inside a scan
    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SCAN))
        else $error("pending compare outside scan");

    // a successful pop removes exactly one record
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hit && (r_kind == krs_pkg::KIND_POP)) |=> (r_count == $past(w_top)))
        else $error("pop did not drop one record");

    // ram writes come only from a push on accept or an update hit
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((w_s_acc && (s_axis_tuser == krs_pkg::KIND_PUSH)) ||
                  (w_hit && (r_kind == krs_pkg::KIND_UPDATE))))
        else $error("unexpected record write");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for keyed_record_stack. A driver feeds commands from a
// queue onto the slave stream; each accepted transaction runs through a local
// copy of the record stack and the answer it gives is queued. A monitor on
// the master stream checks every result against the oldest queued answer.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STACK_DEPTH    = 16;
    localparam int IDLE_PCT       = 21;
    localparam int RANDOM_CMDS    = 1750;
    localparam int HOLDOFF_AT     = 400;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int CALM_FROM      = 900;
    localparam int CALM_TO        = 1150;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    // kinds with no command behind them
    localparam logic [krs_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [krs_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [krs_pkg::KIND_W-1:0] kind;
        logic [krs_pkg::KEY_W-1:0]  record_key;
        logic [krs_pkg::QTY_W-1:0]  quantity;
        logic [krs_pkg::ST_W-1:0]   status;
        logic                       wait_drain;
    } t_cmd;

    typedef struct packed {
        logic [krs_pkg::ERR_W-1:0] error_code;
        logic [krs_pkg::KEY_W-1:0] out_key;
        logic [krs_pkg::QTY_W-1:0] out_quantity;
        logic [krs_pkg::ST_W-1:0]  out_status;
    } t_answer;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // record_key [31:0], quantity [63:32], status [65:64], zero pad [71:66]
    logic [krs_pkg::TDATA_W-1:0]   s_axis_tdata = '0;
    // kind [2:0]
    logic [krs_pkg::KIND_W-1:0]    s_axis_tuser = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // error_code [1:0], out_key [33:2], out_quantity [65:34],
    // out_status [67:66], zero pad [71:68]
    logic [krs_pkg::TDATA_W-1:0]   m_axis_tdata;

    // local copy of the record stack
    logic [krs_pkg::KEY_W-1:0] stack_key [STACK_DEPTH];
    logic [krs_pkg::QTY_W-1:0] stack_qty [STACK_DEPTH];
    logic [krs_pkg::ST_W-1:0]  stack_st  [STACK_DEPTH];
    int                        stack_fill = 0;

    t_cmd    cmd_q[$];
    t_answer answer_q[$];

    int mismatch_count = 0;
    int commands_sent  = 0;
    int results_seen   = 0;
    int holdoff_left   = 0;
    bit holdoff_done   = 1'b0;
    int stall_cycles   = 0;

    keyed_record_stack #(
        .DEPTH(STACK_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // runs one command on the local stack and returns the answer it gives
    function automatic t_answer apply_command(input t_cmd c);
        t_answer a;
        int      i;
        int      hit_idx;
        a = '0;
        hit_idx = -1;
        case (c.kind)
            krs_pkg::KIND_PUSH: begin
                if (stack_fill >= STACK_DEPTH) begin
                    a.error_code = krs_pkg::ERR_FULL;
                end else begin
                    stack_key[stack_fill] = c.record_key;
                    stack_qty[stack_fill] = c.quantity;
                    stack_st[stack_fill]  = c.status;
                    stack_fill++;
                    a.error_code   = krs_pkg::ERR_OK;
                    a.out_key      = c.record_key;
                    a.out_quantity = c.quantity;
                    a.out_status   = c.status;
                end
            end
            krs_pkg::KIND_POP, krs_pkg::KIND_PEEK: begin
                if (stack_fill == 0) begin
                    a.error_code = krs_pkg::ERR_EMPTY;
                end else begin
                    a.error_code   = krs_pkg::ERR_OK;
                    a.out_key      = stack_key[stack_fill-1];
                    a.out_quantity = stack_qty[stack_fill-1];
                    a.out_status   = stack_st[stack_fill-1];
                    if (c.kind == krs_pkg::KIND_POP)
                        stack_fill--;
                end
            end
            krs_pkg::KIND_SEARCH, krs_pkg::KIND_UPDATE: begin
                // topmost match wins
                for (i = stack_fill - 1; i >= 0; i--) begin
                    if (hit_idx < 0 && stack_key[i] == c.record_key)
                        hit_idx = i;
                end
                if (hit_idx < 0) begin
                    a.error_code = krs_pkg::ERR_NOT_FOUND;
                end else begin
                    if (c.kind == krs_pkg::KIND_UPDATE)
                        stack_st[hit_idx] = c.status;
                    a.error_code   = krs_pkg::ERR_OK;
                    a.out_key      = stack_key[hit_idx];
                    a.out_quantity = stack_qty[hit_idx];
                    a.out_status   = stack_st[hit_idx];
                end
            end
            default: begin
                a = '0;
            end
        endcase
        return a;
    endfunction

    task automatic add_cmd(input logic [krs_pkg::KIND_W-1:0] kind,
                           input logic [krs_pkg::KEY_W-1:0] record_key,
                           input logic [krs_pkg::QTY_W-1:0] quantity,
                           input logic [krs_pkg::ST_W-1:0] status,
                           input bit wait_drain);
        t_cmd c;
        c.kind       = kind;
        c.record_key = record_key;
        c.quantity   = quantity;
        c.status     = status;
        c.wait_drain = wait_drain;
        cmd_q.push_back(c);
    endtask

    task automatic report_mismatch(input string what,
                                   input logic [krs_pkg::QTY_W-1:0] got_v,
                                   input logic [krs_pkg::QTY_W-1:0] want_v);
        $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got_v, want_v);
        mismatch_count++;
    endtask

    // random traffic in episodes: filling, draining or mixed, keys mostly
    // from a small per-episode pool so searches and updates hit
    task automatic build_random_traffic(input int total);
        logic [krs_pkg::KEY_W-1:0]  key_pool [6];
        logic [krs_pkg::KIND_W-1:0] kind;
        logic [krs_pkg::KEY_W-1:0]  key;
        int                         made;
        int                         mode;
        int                         run_len;
        int                         r;
        int                         j;
        bit                         drain;
        made = 0;
        while (made < total) begin
            mode = $urandom_range(2);
            run_len = $urandom_range(40, 8);
            for (j = 0; j < 6; j++)
                key_pool[j] = $urandom;
            if ($urandom_range(3) == 0)
                key_pool[0] = ($urandom_range(1) == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
            drain = ($urandom_range(9) == 0);
            for (j = 0; j < run_len && made < total; j++) begin
                r = $urandom_range(99);
                if (r < 3) begin
                    kind = krs_pkg::KIND_W'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
                end else begin
                    r = $urandom_range(99);
                    case (mode)
                        0: kind = (r < 55) ? krs_pkg::KIND_PUSH : (r < 65) ? krs_pkg::KIND_POP :
                                  (r < 75) ? krs_pkg::KIND_PEEK :
                                  (r < 90) ? krs_pkg::KIND_SEARCH : krs_pkg::KIND_UPDATE;
                        1: kind = (r < 10) ? krs_pkg::KIND_PUSH : (r < 60) ? krs_pkg::KIND_POP :
                                  (r < 70) ? krs_pkg::KIND_PEEK :
                                  (r < 85) ? krs_pkg::KIND_SEARCH : krs_pkg::KIND_UPDATE;
                        default: kind = (r < 30) ? krs_pkg::KIND_PUSH :
                                  (r < 55) ? krs_pkg::KIND_POP :
                                  (r < 65) ? krs_pkg::KIND_PEEK :
                                  (r < 85) ? krs_pkg::KIND_SEARCH : krs_pkg::KIND_UPDATE;
                    endcase
                end
                key = ($urandom_range(99) < 82) ? key_pool[$urandom_range(5)] : $urandom;
                add_cmd(kind, key, $urandom, krs_pkg::ST_W'($urandom_range(3)), drain);
                drain = 1'b0;
                made++;
            end
        end
    endtask

    // driver: presents the head of the command queue
    always @(posedge i_clk) begin : driver_proc
        t_cmd taken;
        bit   offer;
        bit   calm;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                taken = cmd_q.pop_front();
                answer_q.push_back(apply_command(taken));
                commands_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                offer = 1'b0;
                calm = (commands_sent >= CALM_FROM && commands_sent < CALM_TO);
                if (cmd_q.size() > 0) begin
                    if (cmd_q[0].wait_drain && answer_q.size() != 0)
                        offer = 1'b0;
                    else
                        offer = calm || ($urandom_range(99) >= IDLE_PCT);
                end
                s_axis_tvalid <= offer;
                if (offer) begin
                    s_axis_tdata <= {{(krs_pkg::TDATA_W-krs_pkg::REC_W){1'b0}},
                                     cmd_q[0].status, cmd_q[0].quantity,
                                     cmd_q[0].record_key};
                    s_axis_tuser <= cmd_q[0].kind;
                end
            end
        end
    end

    // monitor: checks each result transaction and paces tready
    always @(posedge i_clk) begin : monitor_proc
        t_answer got;
        t_answer want;
        bit      ready;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.error_code   = m_axis_tdata[1:0];
                got.out_key      = m_axis_tdata[33:2];
                got.out_quantity = m_axis_tdata[65:34];
                got.out_status   = m_axis_tdata[67:66];
                if (answer_q.size() == 0) begin
                    report_mismatch("result with nothing pending, key", got.out_key, '0);
                end else begin
                    want = answer_q.pop_front();
                    if (got.error_code !== want.error_code)
                        report_mismatch("error_code", krs_pkg::QTY_W'(got.error_code),
                                        krs_pkg::QTY_W'(want.error_code));
                    if (got.out_key !== want.out_key)
                        report_mismatch("out_key", got.out_key, want.out_key);
                    if (got.out_quantity !== want.out_quantity)
                        report_mismatch("out_quantity", got.out_quantity, want.out_quantity);
                    if (got.out_status !== want.out_status)
                        report_mismatch("out_status", krs_pkg::QTY_W'(got.out_status),
                                        krs_pkg::QTY_W'(want.out_status));
                end
                results_seen++;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                ready = 1'b0;
            end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
                // long back-pressure so the block stalls its input
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
                ready = 1'b0;
            end else if (results_seen >= CALM_FROM && results_seen < CALM_TO) begin
                ready = 1'b1;
            end else begin
                ready = ($urandom_range(99) >= IDLE_PCT);
            end
            m_axis_tready <= ready;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int k;

        // empty stack: every reading command and two of the unused kinds
        add_cmd(krs_pkg::KIND_POP,    32'h1234_5678, 32'hffff_ffff, 2'd3, 1'b0);
        add_cmd(krs_pkg::KIND_PEEK,   32'hffff_ffff, 32'h0000_0000, 2'd0, 1'b0);
        add_cmd(krs_pkg::KIND_SEARCH, 32'h0000_0000, 32'h5555_aaaa, 2'd1, 1'b0);
        add_cmd(krs_pkg::KIND_UPDATE, 32'h8000_0000, 32'haaaa_5555, 2'd2, 1'b0);
        add_cmd(KIND_SPARE_LO,        32'hffff_ffff, 32'hffff_ffff, 2'd3, 1'b0);
        add_cmd(KIND_SPARE_HI,        32'h0f0f_0f0f, 32'hf0f0_f0f0, 2'd1, 1'b0);
        // fill to the top, extreme keys and quantities at the bottom
        add_cmd(krs_pkg::KIND_PUSH,   32'h8000_0000, 32'h7fff_ffff, 2'd0, 1'b1);
        add_cmd(krs_pkg::KIND_PUSH,   32'h7fff_ffff, 32'h8000_0000, 2'd3, 1'b0);
        add_cmd(krs_pkg::KIND_PUSH,   32'h0000_0000, 32'h0000_0000, 2'd1, 1'b0);
        add_cmd(krs_pkg::KIND_PUSH,   32'hffff_ffff, 32'hffff_ffff, 2'd2, 1'b0);
        for (k = 4; k < STACK_DEPTH - 1; k++)
            add_cmd(krs_pkg::KIND_PUSH, 32'h100 + k, $urandom,
                    krs_pkg::ST_W'($urandom_range(3)), 1'b0);
        // duplicate key on top: search must stop at the topmost copy
        add_cmd(krs_pkg::KIND_PUSH,   32'h7fff_ffff, 32'h0bad_cafe, 2'd2, 1'b0);
        add_cmd(krs_pkg::KIND_PUSH,   32'h5a5a_5a5a, 32'h1111_1111, 2'd1, 1'b0);
        add_cmd(krs_pkg::KIND_SEARCH, 32'h7fff_ffff, 32'h0, 2'd0, 1'b0);
        add_cmd(krs_pkg::KIND_UPDATE, 32'h8000_0000, 32'h0, 2'd3, 1'b0);
        add_cmd(krs_pkg::KIND_PEEK,   32'h0, 32'h0, 2'd0, 1'b0);
        add_cmd(krs_pkg::KIND_POP,    32'h0, 32'h0, 2'd0, 1'b0);

        build_random_traffic(RANDOM_CMDS);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || answer_q.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (answer_q.size() != 0)
            report_mismatch("results never delivered", krs_pkg::QTY_W'(answer_q.size()), '0);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/krs_pkg.sv
rtl/core/krs_ram.sv
rtl/core/keyed_record_stack.sv
sim/testbench.sv
